// ===== rtl/core/tbsc_pkg.sv =====
// tbsc_pkg: shared types and constants for the two button speed controller
// holds event codes, register indexes, field widths and per button state
// no dependencies
package tbsc_pkg;

  localparam int CNT_W        = 16;
  localparam int LEVEL_W      = 4;
  localparam int DUTY_W       = 12;
  localparam int SFM_W        = 13;
  localparam int EVT_W        = 2;
  localparam int CFG_IDX_W    = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;

  localparam int LEVELS_DEF    = 10;
  localparam int DUTY_BITS_DEF = 12;
  localparam int LEVEL_INIT    = 5;
  localparam int SFM_LOW       = 550;
  localparam int SFM_HIGH      = 5500;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(50);
  localparam logic [CNT_W-1:0] LONG_RESET     = CNT_W'(800);
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = CFG_IDX_W'(1);

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } evt_t;

  typedef struct packed {
    logic             last_raw;
    logic             stable_level;
    logic [CNT_W-1:0] quiet_count;
    logic             press_active;
    logic [CNT_W-1:0] hold_count;
    logic             long_done;
  } btn_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
  } btn_cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/tbsc_button.sv =====
// tbsc_button: debounce and short/long press detection for one button
// advances its state once per accepted tick item
// depends on tbsc_pkg
module tbsc_button (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_en,
  input  logic              raw,
  input  tbsc_pkg::btn_cfg_t cfg,
  output tbsc_pkg::evt_t    evt
);
  import tbsc_pkg::*;

  btn_state_t st_r;
  btn_state_t st_nxt;

  always_comb begin
    logic [CNT_W-1:0] quiet;
    logic [CNT_W-1:0] hold;
    logic             was_stable;
    st_nxt     = st_r;
    evt        = EVT_NONE;
    quiet      = (raw != st_r.last_raw) ? '0 : sat_inc(st_r.quiet_count);
    hold       = st_r.press_active ? sat_inc(st_r.hold_count) : st_r.hold_count;
    was_stable = st_r.stable_level;
    st_nxt.quiet_count = quiet;
    st_nxt.last_raw    = raw;
    st_nxt.hold_count  = hold;
    if (quiet >= cfg.debounce_ticks) begin
      if (was_stable && !raw) begin
        st_nxt.press_active = 1'b1;
        st_nxt.hold_count   = '0;
        st_nxt.long_done    = 1'b0;
      end
      st_nxt.stable_level = raw;
      if (st_nxt.press_active && !raw && !st_nxt.long_done &&
          (st_nxt.hold_count >= cfg.long_press_ticks)) begin
        st_nxt.long_done = 1'b1;
        evt              = EVT_LONG;
      end else if (!was_stable && raw && st_nxt.press_active) begin
        st_nxt.press_active = 1'b0;
        evt                 = st_nxt.long_done ? EVT_NONE : EVT_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_raw     <= 1'b1;
      st_r.stable_level <= 1'b1;
      st_r.quiet_count  <= '0;
      st_r.press_active <= 1'b0;
      st_r.hold_count   <= '0;
      st_r.long_done    <= 1'b0;
    end else if (tick_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/core/two_button_speed_controller.sv =====
// two_button_speed_controller: debounced two button speed and motor control
// result item is registered; one item per cycle while the skid register is empty
// a skid register keeps input accepting while one result waits
// synchronous active low reset: level min(5,LEVELS), motor off, registers at defaults
// depends on tbsc_pkg and tbsc_button
module two_button_speed_controller #(
  parameter int LEVELS    = tbsc_pkg::LEVELS_DEF,
  parameter int DUTY_BITS = tbsc_pkg::DUTY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] up_level, [1] down_level, rest zero
  input  logic [tbsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [11:0] duty, [12] motor_on, [16:13] speed_level, [29:17] surface_speed,
  // [31:30] up_event, [33:32] down_event, rest zero
  output logic [tbsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tbsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbsc_pkg::CNT_W-1:0]           cfg_data
);
  import tbsc_pkg::*;

  localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;
  localparam int LVL_INIT = (LEVEL_INIT > LEVELS) ? LEVELS : LEVEL_INIT;
  localparam int TAB_N    = 1 << LEVEL_W;

  btn_cfg_t           cfg_r;
  logic               motor_r;
  logic               motor_nxt;
  logic [LEVEL_W-1:0] level_r;
  logic [LEVEL_W-1:0] level_nxt;
  evt_t               up_evt;
  evt_t               dn_evt;
  logic               acc;
  logic [OUT_TDATA_W-1:0] res;
  logic               out_v_r;
  logic [OUT_TDATA_W-1:0] out_r;
  logic               skid_v_r;
  logic [OUT_TDATA_W-1:0] skid_r;
  logic [DUTY_W-1:0]  duty_tab [TAB_N];
  logic [SFM_W-1:0]   sfm_tab  [TAB_N];
  logic [DUTY_W-1:0]  duty;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_v_r;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v_r;
  assign m_axis_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= LONG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks   <= cfg_data;
        REG_LONG:     cfg_r.long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  tbsc_button u_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (acc),
    .raw     (s_axis_tdata[0]),
    .cfg     (cfg_r),
    .evt     (up_evt)
  );

  tbsc_button u_down (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (acc),
    .raw     (s_axis_tdata[1]),
    .cfg     (cfg_r),
    .evt     (dn_evt)
  );

  for (genvar l = 0; l < TAB_N; l++) begin : g_tab
    localparam int DV = (l == 0) ? 0 : (l - 1) * DUTY_MAX / (LEVELS - 1);
    localparam int SV = (l == 0) ? SFM_LOW :
                        SFM_LOW + (l - 1) * (SFM_HIGH - SFM_LOW) / (LEVELS - 1);
    assign duty_tab[l] = DUTY_W'(DV);
    assign sfm_tab[l]  = SFM_W'(SV);
  end

  always_comb begin
    motor_nxt = motor_r;
    level_nxt = level_r;
    if (up_evt == EVT_LONG) begin
      motor_nxt = 1'b1;
    end else if (up_evt == EVT_SHORT && level_nxt < LEVEL_W'(LEVELS)) begin
      level_nxt = level_nxt + LEVEL_W'(1);
    end
    if (dn_evt == EVT_LONG) begin
      motor_nxt = 1'b0;
    end else if (dn_evt == EVT_SHORT && level_nxt > LEVEL_W'(1)) begin
      level_nxt = level_nxt - LEVEL_W'(1);
    end
    duty = motor_nxt ? duty_tab[level_nxt] : '0;
    res  = {6'd0, dn_evt, up_evt, sfm_tab[level_nxt], level_nxt, motor_nxt, duty};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_r <= 1'b0;
      level_r <= LEVEL_W'(LVL_INIT);
    end else if (acc) begin
      motor_r <= motor_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || m_axis_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= acc;
      end
    end else if (acc) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || m_axis_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

endmodule
